// ===== design/usc_pkg.sv =====
package usc_pkg;

	// seconds per day, split as 2^7 * 675 for the reciprocal divide
	localparam int unsigned DAY_SECONDS = 86400;
	localparam int unsigned HOUR_SECONDS = 3600;
	localparam int unsigned MINUTE_SECONDS = 60;

	// reciprocals, floor(x / d) == (x * m) >> k over the whole operand range
	localparam logic [25:0] RECIP_DAY = 26'd50903317;   // / 675, k = 35, x < 2^25
	localparam int unsigned SHIFT_DAY = 35;
	localparam logic [16:0] RECIP_WEEK = 17'd74899;     // / 7, k = 19, x < 2^16
	localparam logic [13:0] RECIP_HOUR = 14'd9321;      // / 225, k = 21, x < 2^13
	localparam logic [10:0] RECIP_MIN = 11'd1093;       // / 15, k = 14, x < 2^10
	localparam logic [20:0] RECIP_YEAR = 21'd1469873;   // / 1461, k = 31, x < 2^20
	localparam logic [11:0] RECIP_MON = 12'd3427;       // / 153, k = 19, x < 2^11

	// jdn = days + 2440587 + 1, then shifted by 32044 for the date walk
	localparam logic [21:0] JDN_WALK_BASE = 22'(2440588 + 32044);
	// 2440588 mod 7, so weekday = 1 + (days + 3) mod 7
	localparam logic [15:0] WEEK_OFS = 16'd3;
	localparam int unsigned DAYS_PER_ERA = 146097;
	localparam logic [10:0] DAYS_PER_4Y = 11'd1461;

	// the date range only reaches eras 67, 68 and 69 of the shifted day count
	localparam int unsigned ERA_FIRST = 67;
	localparam logic [23:0] ERA_EDGE_1 = 24'(DAYS_PER_ERA * (ERA_FIRST + 1));
	localparam logic [23:0] ERA_EDGE_2 = 24'(DAYS_PER_ERA * (ERA_FIRST + 2));

	typedef logic [1:0] era_sel_t;

	// (146097 * era) / 4 for each reachable era
	function automatic logic [21:0] era_start(input era_sel_t sel);
		logic [21:0] base;
		case (sel)
			2'd0: base = 22'((DAYS_PER_ERA * ERA_FIRST) / 4);
			2'd1: base = 22'((DAYS_PER_ERA * (ERA_FIRST + 1)) / 4);
			2'd2: base = 22'((DAYS_PER_ERA * (ERA_FIRST + 2)) / 4);
			default: base = 22'd0;
		endcase
		return base;
	endfunction

	// year - 6800 contributed by the era, modulo 256
	function automatic logic [7:0] era_year_ofs(input era_sel_t sel);
		logic [7:0] ofs;
		case (sel)
			2'd0: ofs = 8'(-100);
			2'd1: ofs = 8'd0;
			2'd2: ofs = 8'd100;
			default: ofs = 8'd0;
		endcase
		return ofs;
	endfunction

	// (153 * m + 2) / 5, first day of a march-based month
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] first;
		case (m)
			4'd0: first = 9'd0;
			4'd1: first = 9'd31;
			4'd2: first = 9'd61;
			4'd3: first = 9'd92;
			4'd4: first = 9'd122;
			4'd5: first = 9'd153;
			4'd6: first = 9'd184;
			4'd7: first = 9'd214;
			4'd8: first = 9'd245;
			4'd9: first = 9'd275;
			4'd10: first = 9'd306;
			4'd11: first = 9'd337;
			default: first = 9'd0;
		endcase
		return first;
	endfunction

endpackage

// ===== design/unix_seconds_to_calendar_core.sv =====
// unix seconds to gregorian calendar converter
//
// input channel: in_valid / in_ready with unix_seconds, an unsigned 32-bit count
// of seconds since 1970-01-01 00:00:00 utc; every value is legal
// output channel: out_valid / out_ready with year_offset (year - 2000, signed),
// month, day_of_month, weekday (1 monday .. 7 sunday), hour, minute and
// second_of_minute; one result word per input word, in order
//
// seven register stages; a word accepted at an edge is registered in stage 1 and moves
// through stages 2 to 7, the output register, before it can be taken; one word per
// cycle is accepted and delivered while out_ready stays high
// every divide is by a constant and is a reciprocal multiply, at most two
// independent constant multiplies per stage, so the multipliers set the depth
//
// each stage holds a valid bit and advances when it is empty or the next stage
// advances, so bubbles are squeezed out and a stalled output still lets new
// words fill the empty stages behind it; in_ready drops only when all seven
// stages are full and out_ready is low
// reset clears all valid bits, nothing else needs clearing
module unix_seconds_to_calendar_core
	import usc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       unix_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] year_offset,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month,
	output logic [2:0]        weekday,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second_of_minute
);

	localparam int NUM_STAGES = 7;

	// stage control
	logic [NUM_STAGES:1]   stage_vld_q;
	logic [NUM_STAGES+1:1] stage_en;
	logic [NUM_STAGES:1]   vld_next;

	// a stage takes new data when it is empty or its contents move on
	always_comb begin
		stage_en[NUM_STAGES+1] = out_ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			stage_en[k] = ~stage_vld_q[k] | stage_en[k+1];
		end
	end

	assign vld_next = {stage_vld_q[NUM_STAGES-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= (stage_en[NUM_STAGES:1] & vld_next)
				| (~stage_en[NUM_STAGES:1] & stage_vld_q);
		end
	end

	assign in_ready = stage_en[1];
	assign out_valid = stage_vld_q[NUM_STAGES];

	// stage 1: whole days, seconds / 86400 as (seconds >> 7) / 675
	logic [50:0] day_prod;
	logic [31:0] secs_s1;
	logic [15:0] days_s1;

	assign day_prod = 51'(unix_seconds[31:7]) * 51'(RECIP_DAY);

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			secs_s1 <= unix_seconds;
			days_s1 <= day_prod[SHIFT_DAY+15:SHIFT_DAY];
		end
	end

	// stage 2: time of day, era of the shifted day number, week quotient
	logic [31:0] day_start;
	logic [21:0] walk_day;
	logic [23:0] walk_day4;
	era_sel_t    era_sel;
	logic [15:0] week_sum;
	logic [32:0] week_prod;

	logic [16:0] tod_s2;
	logic [21:0] walk_day_s2;
	era_sel_t    era_s2;
	logic [15:0] week_sum_s2;
	logic [13:0] week_quo_s2;

	assign day_start = 32'(days_s1) * 32'(DAY_SECONDS);
	assign walk_day = 22'(days_s1) + JDN_WALK_BASE;
	assign walk_day4 = {walk_day, 2'b11};
	assign week_sum = days_s1 + WEEK_OFS;
	assign week_prod = 33'(week_sum) * 33'(RECIP_WEEK);

	always_comb begin
		if (walk_day4 >= ERA_EDGE_2) begin
			era_sel = 2'd2;
		end else if (walk_day4 >= ERA_EDGE_1) begin
			era_sel = 2'd1;
		end else begin
			era_sel = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			tod_s2 <= 17'(secs_s1 - day_start);
			walk_day_s2 <= walk_day;
			era_s2 <= era_sel;
			week_sum_s2 <= week_sum;
			week_quo_s2 <= week_prod[32:19];
		end
	end

	// stage 3: day within the era, weekday, hour
	logic [15:0] week_back;
	logic [15:0] week_rem;
	logic [26:0] hour_prod;

	logic [16:0] tod_s3;
	logic [4:0]  hour_s3;
	logic [17:0] era_day_s3;
	era_sel_t    era_s3;
	logic [2:0]  wday_s3;

	assign week_back = 16'(week_quo_s2) * 16'd7;
	assign week_rem = week_sum_s2 - week_back;
	assign hour_prod = 27'(tod_s2[16:4]) * 27'(RECIP_HOUR);

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			tod_s3 <= tod_s2;
			hour_s3 <= hour_prod[25:21];
			era_day_s3 <= 18'(walk_day_s2 - era_start(era_s2));
			era_s3 <= era_s2;
			wday_s3 <= week_rem[2:0] + 3'd1;
		end
	end

	// stage 4: seconds within the hour, year within the era
	logic [16:0] hour_start;
	logic [19:0] era_day4;
	logic [40:0] cyc_prod;

	logic [11:0] sec_in_hour_s4;
	logic [4:0]  hour_s4;
	logic [8:0]  cyc_s4;
	logic [17:0] era_day_s4;
	era_sel_t    era_s4;
	logic [2:0]  wday_s4;

	assign hour_start = 17'(hour_s3) * 17'(HOUR_SECONDS);
	assign era_day4 = {era_day_s3, 2'b11};
	assign cyc_prod = 41'(era_day4) * 41'(RECIP_YEAR);

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			sec_in_hour_s4 <= 12'(tod_s3 - hour_start);
			hour_s4 <= hour_s3;
			cyc_s4 <= cyc_prod[39:31];
			era_day_s4 <= era_day_s3;
			era_s4 <= era_s3;
			wday_s4 <= wday_s3;
		end
	end

	// stage 5: minute, day within the year (march based)
	logic [20:0] min_prod;
	logic [19:0] cyc_days;

	logic [11:0] sec_in_hour_s5;
	logic [5:0]  minute_s5;
	logic [4:0]  hour_s5;
	logic [8:0]  cyc_s5;
	logic [8:0]  year_day_s5;
	era_sel_t    era_s5;
	logic [2:0]  wday_s5;

	assign min_prod = 21'(sec_in_hour_s4[11:2]) * 21'(RECIP_MIN);
	assign cyc_days = 20'(cyc_s4) * 20'(DAYS_PER_4Y);

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			sec_in_hour_s5 <= sec_in_hour_s4;
			minute_s5 <= min_prod[19:14];
			hour_s5 <= hour_s4;
			cyc_s5 <= cyc_s4;
			year_day_s5 <= 9'(era_day_s4 - cyc_days[19:2]);
			era_s5 <= era_s4;
			wday_s5 <= wday_s4;
		end
	end

	// stage 6: second, march-based month index
	logic [11:0] min_start;
	logic [10:0] mon_arg;
	logic [22:0] mon_prod;

	logic [5:0]  second_s6;
	logic [5:0]  minute_s6;
	logic [4:0]  hour_s6;
	logic [8:0]  cyc_s6;
	logic [8:0]  year_day_s6;
	logic [3:0]  mon_idx_s6;
	era_sel_t    era_s6;
	logic [2:0]  wday_s6;

	assign min_start = 12'(minute_s5) * 12'(MINUTE_SECONDS);
	assign mon_arg = 11'({year_day_s5, 2'b00}) + 11'(year_day_s5) + 11'd2;
	assign mon_prod = 23'(mon_arg) * 23'(RECIP_MON);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			second_s6 <= 6'(sec_in_hour_s5 - min_start);
			minute_s6 <= minute_s5;
			hour_s6 <= hour_s5;
			cyc_s6 <= cyc_s5;
			year_day_s6 <= year_day_s5;
			mon_idx_s6 <= mon_prod[22:19];
			era_s6 <= era_s5;
			wday_s6 <= wday_s5;
		end
	end

	// stage 7: output register, day, month and year offset
	logic       past_dec;
	logic [8:0] day_calc;

	logic [7:0] year_offset_s7;
	logic [3:0] month_s7;
	logic [4:0] day_s7;
	logic [2:0] wday_s7;
	logic [4:0] hour_s7;
	logic [5:0] minute_s7;
	logic [5:0] second_s7;

	// january and february belong to the next calendar year
	assign past_dec = (mon_idx_s6 >= 4'd10);
	assign day_calc = year_day_s6 - month_start(mon_idx_s6) + 9'd1;

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			year_offset_s7 <= 8'(cyc_s6) + 8'(past_dec) + era_year_ofs(era_s6);
			month_s7 <= past_dec ? (mon_idx_s6 - 4'd9) : (mon_idx_s6 + 4'd3);
			day_s7 <= day_calc[4:0];
			wday_s7 <= wday_s6;
			hour_s7 <= hour_s6;
			minute_s7 <= minute_s6;
			second_s7 <= second_s6;
		end
	end

	assign year_offset = $signed(year_offset_s7);
	assign month = month_s7;
	assign day_of_month = day_s7;
	assign weekday = wday_s7;
	assign hour = hour_s7;
	assign minute = minute_s7;
	assign second_of_minute = second_s7;

	// a taking receiver never holds up the input
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while output is taken");

	// march-based month index and day of year stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[6] |-> (mon_idx_s6 <= 4'd11) && (year_day_s6 <= 9'd365))
		else $error("month index or day of year out of range");

	// delivered date fields are legal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
			&& (weekday >= 3'd1) && (weekday <= 3'd7))
		else $error("date field out of range");

	// delivered time fields are legal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second_of_minute <= 6'd59))
		else $error("time field out of range");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	// calendar fields of one result word, in port order
	typedef struct packed {
		logic signed [7:0] year_offset;
		logic [3:0]        month;
		logic [4:0]        day_of_month;
		logic [2:0]        weekday;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second_of_minute;
	} cal_word_t;

	localparam longint unsigned DAY_SECS   = 86400;
	localparam longint unsigned HOUR_SECS  = 3600;
	localparam longint unsigned MIN_SECS   = 60;
	localparam longint unsigned EPOCH_JDN  = 2440588;
	localparam longint unsigned JDN_SHIFT  = 32044;
	localparam longint unsigned ERA_DAYS   = 146097;
	localparam longint unsigned QUAD_DAYS  = 1461;
	localparam longint unsigned MON5_DAYS  = 153;
	localparam longint unsigned YEAR_BIAS  = 6800;   // 4800 shift plus the 2000 base
	localparam int unsigned     LAST_DAY   = 49709;  // last day that has all 86400 seconds

	localparam int unsigned RANDOM_PHASES = 7;
	localparam int unsigned PHASE_WORDS   = 250;
	localparam int unsigned LONG_HOLD     = 64;
	localparam int unsigned TAIL_CYCLES   = 20;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned REPORT_LIMIT  = 10;

	// expected calendar words, oldest first, with the timestamp behind each
	class calendar_scoreboard;
		cal_word_t   expected_q[$];
		logic [31:0] secs_q[$];
		int unsigned mismatches = 0;
		int unsigned failures = 0;

		function cal_word_t calendar_of(logic [31:0] secs);
			longint unsigned s, tod, jdn, a, b, c, d, yr;
			cal_word_t w;
			s = 64'(secs);
			tod = s % DAY_SECS;
			jdn = s / DAY_SECS + EPOCH_JDN;
			a = jdn + JDN_SHIFT;
			b = (4 * a + 3) / ERA_DAYS;
			a = a - (ERA_DAYS * b) / 4;
			c = (4 * a + 3) / QUAD_DAYS;
			a = a - (QUAD_DAYS * c) / 4;
			d = (5 * a + 2) / MON5_DAYS;
			yr = 100 * b + c + d / 10;
			w.year_offset      = 8'(yr - YEAR_BIAS);
			w.month            = 4'(d + 3 - 12 * (d / 10));
			w.day_of_month     = 5'(a - (MON5_DAYS * d + 2) / 5 + 1);
			w.weekday          = 3'(1 + jdn % 7);
			w.hour             = 5'(tod / HOUR_SECS);
			w.minute           = 6'((tod % HOUR_SECS) / MIN_SECS);
			w.second_of_minute = 6'(tod % MIN_SECS);
			return w;
		endfunction

		function void note_input(logic [31:0] secs);
			expected_q.push_back(calendar_of(secs));
			secs_q.push_back(secs);
		endfunction

		function void check_result(cal_word_t got);
			cal_word_t   want;
			logic [31:0] secs;
			if (expected_q.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result word with nothing expected: %p", $time, got);
				return;
			end
			want = expected_q.pop_front();
			secs = secs_q.pop_front();
			if (got.year_offset !== want.year_offset || got.month !== want.month ||
					got.day_of_month !== want.day_of_month || got.weekday !== want.weekday ||
					got.hour !== want.hour || got.minute !== want.minute ||
					got.second_of_minute !== want.second_of_minute) begin
				failures++;
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch for unix_seconds %0d", $time, secs);
					$display("  expected y%0d m%0d d%0d wd%0d %0d:%0d:%0d", want.year_offset,
						want.month, want.day_of_month, want.weekday, want.hour, want.minute,
						want.second_of_minute);
					$display("  actual   y%0d m%0d d%0d wd%0d %0d:%0d:%0d", got.year_offset,
						got.month, got.day_of_month, got.weekday, got.hour, got.minute,
						got.second_of_minute);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		// anything still waiting at the end never came out
		function void close_out();
			if (expected_q.size() != 0) begin
				failures += expected_q.size();
				$display("%0t: %0d result words never arrived", $time, expected_q.size());
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        unix_seconds = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [7:0]  year_offset;
	logic [3:0]         month;
	logic [4:0]         day_of_month;
	logic [2:0]         weekday;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second_of_minute;

	// idling knobs, written by the stimulus process; the receiver clears long_hold_req
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	bit long_hold_req = 1'b0;

	int unsigned idle_cycles = 0;

	calendar_scoreboard sb = new();

	unix_seconds_to_calendar_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.unix_seconds     (unix_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.year_offset      (year_offset),
		.month            (month),
		.day_of_month     (day_of_month),
		.weekday          (weekday),
		.hour             (hour),
		.minute           (minute),
		.second_of_minute (second_of_minute)
	);

	always #5 clk = ~clk;

	// monitors sample at the edge, so they see the values from before it
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(unix_seconds);
	end

	always @(posedge clk) begin : result_mon
		cal_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.year_offset      = year_offset;
			got.month            = month;
			got.day_of_month     = day_of_month;
			got.weekday          = weekday;
			got.hour             = hour;
			got.minute           = minute;
			got.second_of_minute = second_of_minute;
			sb.check_result(got);
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: a random stall before each result word, or one long hold on request
	initial begin : rx_side
		int unsigned n;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = rx_gaps_on ? $urandom_range(0, 7) : 0;
			end
			repeat (n) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	function automatic logic [31:0] secs_at(int unsigned day, int unsigned tod);
		return 32'(longint'(day) * DAY_SECS + tod);
	endfunction

	// offer one word after a gap, hold it until the block takes it
	task automatic send_word(input logic [31:0] secs);
		int unsigned gap;
		gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= secs;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// stop offering and wait for every expected result word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// random timestamp, weighted toward day edges and the top of the range
	function automatic logic [31:0] random_secs();
		int unsigned day;
		logic [31:0] secs;
		day = $urandom_range(0, LAST_DAY);
		case ($urandom_range(0, 3))
			0: secs = $urandom;
			1: begin
				// around midnight
				case ($urandom_range(0, 3))
					0: secs = secs_at(day, 0);
					1: secs = secs_at(day, 1);
					2: secs = secs_at(day, 86398);
					default: secs = secs_at(day, 86399);
				endcase
			end
			2: secs = secs_at(day, $urandom_range(0, 86399));
			default: secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		endcase
		return secs;
	endfunction

	initial begin : stimulus
		logic [31:0] directed_q[$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, time of day edges, every weekday, leap days, century edges
		directed_q = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			secs_at(2, 43200), secs_at(3, 7261), secs_at(4, 82800), secs_at(5, 59),
			secs_at(6, 86399),
			secs_at(789, 0),                       // 1972-02-29
			32'd946684799, 32'd946684800,          // into 2000
			secs_at(11016, 86399), secs_at(11017, 0), // 2000-02-29 into march
			secs_at(47540, 86399), secs_at(47541, 0), // 2100 has no feb 29
			32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
		};
		foreach (directed_q[i])
			send_word(directed_q[i]);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 3)
				0: begin
					tx_gaps_on = 1'b1;
					rx_gaps_on = 1'b1;
				end
				1: begin
					tx_gaps_on = 1'b0;
					rx_gaps_on = 1'b0;
				end
				default: begin
					tx_gaps_on = 1'($urandom_range(0, 1));
					rx_gaps_on = 1'($urandom_range(0, 1));
				end
			endcase
			// one phase with a long receiver hold while the sender keeps pushing
			if (p == 3) begin
				tx_gaps_on = 1'b0;
				long_hold_req = 1'b1;
			end
			repeat (PHASE_WORDS)
				send_word(random_secs());
			// sender pause until the pipeline is empty
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/usc_pkg.sv
design/unix_seconds_to_calendar_core.sv
dv/testbench.sv
